FILE: rtl/core/s2hsv_pkg.sv
// ----------------------------------------------------------------------------
// s2hsv_pkg
// Shared types, constants and the linearization table builder for the sRGB
// to HSV converter.
// ----------------------------------------------------------------------------
package s2hsv_pkg;

	// Hue is kept in 1/64 degree units: 3840 per 60-degree sector.
	localparam int HUE_BITS     = 15;
	localparam int HUE_SUM_W    = HUE_BITS + 2;
	localparam int HUE_Q_BITS   = 12;
	localparam int SECTOR_SPAN  = 3840;
	localparam int FULL_TURN    = 23040;

	localparam logic [HUE_BITS-1:0] BASE_RED   = 15'd0;
	localparam logic [HUE_BITS-1:0] BASE_GREEN = 15'd7680;
	localparam logic [HUE_BITS-1:0] BASE_BLUE  = 15'd15360;

	// Which channel holds the maximum, after tie breaking.
	typedef enum logic [1:0] {
		SECTOR_RED,
		SECTOR_GREEN,
		SECTOR_BLUE
	} s2hsv_sector_t;

	// Control word that travels down the pipeline with each pixel.
	typedef struct packed {
		logic          valid;
		logic          black;
		logic          grey;
		logic          negate;
		s2hsv_sector_t sector;
	} s2hsv_ctrl_t;

	// Table entry c: round half up of lmax * lin(c / cmax), found exactly
	// by a search over candidate results. The linear segment tests
	// y * 2584 * cmax <= 200 * c * lmax + 1292 * cmax; the power segment
	// tests (2y - 1)^5 * d^12 <= 32 * lmax^5 * n^12 with n / d the scaled
	// input of the 2.4 power. Evaluated only during elaboration.
	function automatic logic [31:0] lin_entry(input longint unsigned code,
			input int unsigned cbits, input int unsigned lbits);
		longint unsigned cmax;
		longint unsigned lmax;
		longint unsigned lnum;
		longint unsigned lden;
		longint unsigned n;
		longint unsigned d;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		logic [511:0]    rhs;
		logic [511:0]    lhs;
		logic [511:0]    dpow;
		logic            on_line;
		logic            fits;
		cmax = (64'd1 << cbits) - 64'd1;
		lmax = (64'd1 << lbits) - 64'd1;
		on_line = (code * 64'd100000) <= (64'd4045 * cmax);
		lnum = 64'd200 * code * lmax + 64'd1292 * cmax;
		lden = 64'd2584 * cmax;
		n = 64'd1000 * code + 64'd55 * cmax;
		d = 64'd1055 * cmax;
		rhs = 512'd32;
		for (int i = 0; i < 5; i++) begin
			rhs = rhs * 512'(lmax);
		end
		for (int i = 0; i < 12; i++) begin
			rhs = rhs * 512'(n);
		end
		dpow = 512'd1;
		for (int i = 0; i < 12; i++) begin
			dpow = dpow * 512'(d);
		end
		lo = 64'd0;
		hi = lmax;
		while (lo < hi) begin
			mid = lo + ((hi - lo + 64'd1) >> 1);
			if (on_line) begin
				fits = (mid * lden) <= lnum;
			end else begin
				lhs = 512'd1;
				for (int i = 0; i < 5; i++) begin
					lhs = lhs * 512'(64'd2 * mid - 64'd1);
				end
				lhs = lhs * dpow;
				fits = lhs <= rhs;
			end
			if (fits) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return 32'(lo);
	endfunction

endpackage

FILE: rtl/core/s2hsv_lin_rom.sv
// ----------------------------------------------------------------------------
// s2hsv_lin_rom
// Constant sRGB linearization table with three registered read ports, one
// for each color channel.
// ----------------------------------------------------------------------------
module s2hsv_lin_rom #(
	parameter int CODE_BITS   = 8,
	parameter int LINEAR_BITS = 16
) (
	input  logic                   clk,
	input  logic [CODE_BITS-1:0]   red_code,
	input  logic [CODE_BITS-1:0]   green_code,
	input  logic [CODE_BITS-1:0]   blue_code,
	output logic [LINEAR_BITS-1:0] red_lin_s1,
	output logic [LINEAR_BITS-1:0] green_lin_s1,
	output logic [LINEAR_BITS-1:0] blue_lin_s1
);
	import s2hsv_pkg::*;

	localparam int ROM_SIZE = 1 << CODE_BITS;

	logic [LINEAR_BITS-1:0] rom_w [ROM_SIZE];

	// Every entry is fixed at elaboration.
	for (genvar i = 0; i < ROM_SIZE; i++) begin : g_entry
		localparam logic [31:0] ENTRY = lin_entry(longint'(i), CODE_BITS, LINEAR_BITS);
		assign rom_w[i] = ENTRY[LINEAR_BITS-1:0];
	end

	// Registered lookup of all three channels.
	always_ff @(posedge clk) begin
		red_lin_s1   <= rom_w[red_code];
		green_lin_s1 <= rom_w[green_code];
		blue_lin_s1  <= rom_w[blue_code];
	end

endmodule

FILE: rtl/core/s2hsv_sector.sv
// ----------------------------------------------------------------------------
// s2hsv_sector
// Finds maximum, minimum and hue sector of the linear channels and forms the
// magnitude and sign of the hue numerator.
// ----------------------------------------------------------------------------
module s2hsv_sector #(
	parameter int LINEAR_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	input  logic [LINEAR_BITS-1:0]  red_lin_s1,
	input  logic [LINEAR_BITS-1:0]  green_lin_s1,
	input  logic [LINEAR_BITS-1:0]  blue_lin_s1,
	output logic [LINEAR_BITS-1:0]  max_s2,
	output logic [LINEAR_BITS-1:0]  diff_s2,
	output logic [LINEAR_BITS-1:0]  anum_s2,
	output s2hsv_pkg::s2hsv_ctrl_t  ctrl_s2
);
	import s2hsv_pkg::*;

	logic [LINEAR_BITS-1:0] mx;
	logic [LINEAR_BITS-1:0] mn;
	logic [LINEAR_BITS-1:0] anum;
	logic                   negate;
	s2hsv_sector_t          sector;

	// Extremes, then the sector: blue wins ties over green, green over red.
	always_comb begin
		mx = red_lin_s1;
		if (green_lin_s1 > mx) begin
			mx = green_lin_s1;
		end
		if (blue_lin_s1 > mx) begin
			mx = blue_lin_s1;
		end
		mn = red_lin_s1;
		if (green_lin_s1 < mn) begin
			mn = green_lin_s1;
		end
		if (blue_lin_s1 < mn) begin
			mn = blue_lin_s1;
		end
		if (blue_lin_s1 == mx) begin
			sector = SECTOR_BLUE;
			negate = green_lin_s1 > red_lin_s1;
			anum   = negate ? green_lin_s1 - red_lin_s1 : red_lin_s1 - green_lin_s1;
		end else if (green_lin_s1 == mx) begin
			sector = SECTOR_GREEN;
			negate = red_lin_s1 > blue_lin_s1;
			anum   = negate ? red_lin_s1 - blue_lin_s1 : blue_lin_s1 - red_lin_s1;
		end else begin
			sector = SECTOR_RED;
			negate = blue_lin_s1 > green_lin_s1;
			anum   = negate ? blue_lin_s1 - green_lin_s1 : green_lin_s1 - blue_lin_s1;
		end
	end

	// Control word carries the valid bit and needs reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2.valid  <= valid_s1;
			ctrl_s2.black  <= mx == '0;
			ctrl_s2.grey   <= mx == mn;
			ctrl_s2.negate <= negate;
			ctrl_s2.sector <= sector;
		end
	end

	// Data words.
	always_ff @(posedge clk) begin
		max_s2  <= mx;
		diff_s2 <= mx - mn;
		anum_s2 <= anum;
	end

endmodule

FILE: rtl/core/s2hsv_div_pipe.sv
// ----------------------------------------------------------------------------
// s2hsv_div_pipe
// Pipelined restoring divider, one quotient bit per stage, most significant
// bit first. The quotient must fit in Q_BITS bits.
// ----------------------------------------------------------------------------
module s2hsv_div_pipe #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 16,
	parameter int Q_BITS = 16
) (
	input  logic              clk,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [Q_BITS-1:0] quo,
	output logic              rem_nz
);
	import s2hsv_pkg::*;

	localparam int CMP_W = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

	// Entry k holds the partial result after stage k.
	logic [NUM_W-1:0]  rem_s [1:Q_BITS];
	logic [DEN_W-1:0]  den_s [1:Q_BITS];
	logic [Q_BITS-1:0] quo_s [1:Q_BITS];

	for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
		localparam int BIT = Q_BITS - 1 - k;

		logic [NUM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [Q_BITS-1:0] quo_in;
		logic [CMP_W-1:0]  trial;
		logic              fit;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign quo_in = quo_s[k];
		end

		// Try the divisor shifted to this bit position.
		always_comb begin
			trial = CMP_W'(den_in) << BIT;
			fit   = CMP_W'(rem_in) >= trial;
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_in;
			if (fit) begin
				rem_s[k+1] <= NUM_W'(CMP_W'(rem_in) - trial);
				quo_s[k+1] <= quo_in | (Q_BITS'(1) << BIT);
			end else begin
				rem_s[k+1] <= rem_in;
				quo_s[k+1] <= quo_in;
			end
		end
	end

	assign quo    = quo_s[Q_BITS];
	assign rem_nz = |rem_s[Q_BITS];

endmodule

FILE: rtl/core/srgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// srgb_to_hsv_converter_top
// Converts one sRGB pixel per clock to linear-light hue, saturation, value.
// ----------------------------------------------------------------------------
// A pixel word is taken at every clock edge where start is high and busy is
// low; busy is high only in the first cycle after reset, so one pixel per
// cycle is accepted from then on. Each result word appears on hue,
// saturation and value for a single cycle, flagged by done. Each pixel
// passes through table lookup, sector search, dividend setup, the two
// dividers, which produce one quotient bit per pipeline stage, and the
// output register. Results cannot be held off; the receiver must take
// every word.
// ----------------------------------------------------------------------------
module srgb_to_hsv_converter_top #(
	parameter int CODE_BITS   = 8,
	parameter int LINEAR_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [CODE_BITS-1:0]             red_code,
	input  logic [CODE_BITS-1:0]             green_code,
	input  logic [CODE_BITS-1:0]             blue_code,
	output logic                             done,
	output logic [s2hsv_pkg::HUE_BITS-1:0]   hue,
	output logic [LINEAR_BITS-1:0]           saturation,
	output logic [LINEAR_BITS-1:0]           value
);
	import s2hsv_pkg::*;

	localparam int DIV_STAGES = (LINEAR_BITS > HUE_Q_BITS) ? LINEAR_BITS : HUE_Q_BITS;
	localparam int SAT_NUM_W  = 2 * LINEAR_BITS;
	localparam int HUE_NUM_W  = LINEAR_BITS + HUE_Q_BITS;
	localparam int LATENCY    = DIV_STAGES + 4;
	localparam logic [LINEAR_BITS-1:0] LMAX = {LINEAR_BITS{1'b1}};

	logic                      busy_q;
	logic                      accept;
	logic                      valid_s1;
	logic [LINEAR_BITS-1:0]    red_lin_s1;
	logic [LINEAR_BITS-1:0]    green_lin_s1;
	logic [LINEAR_BITS-1:0]    blue_lin_s1;
	logic [LINEAR_BITS-1:0]    max_s2;
	logic [LINEAR_BITS-1:0]    diff_s2;
	logic [LINEAR_BITS-1:0]    anum_s2;
	s2hsv_ctrl_t               ctrl_s2;
	logic [SAT_NUM_W-1:0]      sat_num_s3;
	logic [HUE_NUM_W-1:0]      hue_num_s3;
	logic [LINEAR_BITS-1:0]    max_s3;
	logic [LINEAR_BITS-1:0]    diff_s3;
	s2hsv_ctrl_t               ctrl_s3;
	s2hsv_ctrl_t               ctrl_div_s [1:DIV_STAGES];
	logic [LINEAR_BITS-1:0]    max_div_s  [1:DIV_STAGES];
	logic [DIV_STAGES-1:0]     sat_quo;
	logic [DIV_STAGES-1:0]     hue_quo;
	logic                      hue_rem_nz;
	s2hsv_ctrl_t               ctrl_out;
	logic [HUE_Q_BITS:0]       hue_mag;
	logic [HUE_BITS-1:0]       hue_base;
	logic signed [HUE_SUM_W-1:0] hue_sum;
	logic signed [HUE_SUM_W-1:0] hue_wrap;
	logic                      done_q;
	logic [HUE_BITS-1:0]       hue_q;
	logic [LINEAR_BITS-1:0]    saturation_q;
	logic [LINEAR_BITS-1:0]    value_q;

	// Busy only while coming out of reset; the pipeline never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
		end
	end

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Stage 1: linearization table.
	s2hsv_lin_rom #(
		.CODE_BITS   (CODE_BITS),
		.LINEAR_BITS (LINEAR_BITS)
	) u_lin_rom (
		.clk          (clk),
		.red_code     (red_code),
		.green_code   (green_code),
		.blue_code    (blue_code),
		.red_lin_s1   (red_lin_s1),
		.green_lin_s1 (green_lin_s1),
		.blue_lin_s1  (blue_lin_s1)
	);

	// Stage 2: extremes and sector.
	s2hsv_sector #(
		.LINEAR_BITS (LINEAR_BITS)
	) u_sector (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.red_lin_s1   (red_lin_s1),
		.green_lin_s1 (green_lin_s1),
		.blue_lin_s1  (blue_lin_s1),
		.max_s2       (max_s2),
		.diff_s2      (diff_s2),
		.anum_s2      (anum_s2),
		.ctrl_s2      (ctrl_s2)
	);

	// Stage 3: scaled dividends for saturation and hue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sat_num_s3 <= SAT_NUM_W'(diff_s2) * SAT_NUM_W'(LMAX);
		hue_num_s3 <= HUE_NUM_W'(anum_s2) * HUE_NUM_W'(SECTOR_SPAN);
		max_s3     <= max_s2;
		diff_s3    <= diff_s2;
	end

	// Divider stages: saturation by the maximum, hue by the spread.
	s2hsv_div_pipe #(
		.NUM_W  (SAT_NUM_W),
		.DEN_W  (LINEAR_BITS),
		.Q_BITS (DIV_STAGES)
	) u_sat_div (
		.clk    (clk),
		.num    (sat_num_s3),
		.den    (max_s3),
		.quo    (sat_quo),
		.rem_nz ()
	);

	s2hsv_div_pipe #(
		.NUM_W  (HUE_NUM_W),
		.DEN_W  (LINEAR_BITS),
		.Q_BITS (DIV_STAGES)
	) u_hue_div (
		.clk    (clk),
		.num    (hue_num_s3),
		.den    (diff_s3),
		.quo    (hue_quo),
		.rem_nz (hue_rem_nz)
	);

	// Side data follows the dividers stage by stage.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_side
		if (k == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctrl_div_s[k] <= '0;
				end else begin
					ctrl_div_s[k] <= ctrl_s3;
				end
			end
			always_ff @(posedge clk) begin
				max_div_s[k] <= max_s3;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctrl_div_s[k] <= '0;
				end else begin
					ctrl_div_s[k] <= ctrl_div_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				max_div_s[k] <= max_div_s[k-1];
			end
		end
	end

	assign ctrl_out = ctrl_div_s[DIV_STAGES];

	// Hue assembly: a negative numerator rounds its magnitude up, and a
	// negative total wraps by a full turn.
	always_comb begin
		case (ctrl_out.sector)
			SECTOR_RED:   hue_base = BASE_RED;
			SECTOR_GREEN: hue_base = BASE_GREEN;
			SECTOR_BLUE:  hue_base = BASE_BLUE;
			default:      hue_base = BASE_RED;
		endcase
		hue_mag = (HUE_Q_BITS + 1)'(hue_quo[HUE_Q_BITS-1:0])
			+ (HUE_Q_BITS + 1)'(ctrl_out.negate & hue_rem_nz);
		if (ctrl_out.negate) begin
			hue_sum = $signed(HUE_SUM_W'(hue_base)) - $signed(HUE_SUM_W'(hue_mag));
		end else begin
			hue_sum = $signed(HUE_SUM_W'(hue_base)) + $signed(HUE_SUM_W'(hue_mag));
		end
		if (hue_sum < 0) begin
			hue_wrap = hue_sum + $signed(HUE_SUM_W'(FULL_TURN));
		end else begin
			hue_wrap = hue_sum;
		end
	end

	// Output register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_out.black) begin
			hue_q        <= '0;
			saturation_q <= '0;
			value_q      <= '0;
		end else begin
			hue_q        <= ctrl_out.grey ? '0 : HUE_BITS'(hue_wrap);
			saturation_q <= sat_quo[LINEAR_BITS-1:0];
			value_q      <= max_div_s[DIV_STAGES];
		end
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = saturation_q;
	assign value      = value_q;

	// Every accepted pixel yields its result strobe.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy, LATENCY) |-> done)
		else $error("accepted pixel without its result strobe");

	// A result strobe only ever follows an accepted pixel.
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted pixel");

	// Hue stays within one turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hue < HUE_BITS'(FULL_TURN))
		else $error("hue beyond a full turn");

	// A black pixel gives zero hue and saturation.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && value == '0) |-> (hue == '0 && saturation == '0))
		else $error("black pixel with nonzero hue or saturation");

endmodule

FILE: test/srgb_to_hsv_checker.sv
// ----------------------------------------------------------------------------
// srgb_to_hsv_checker
// Watches the pixel and result channels of the sRGB to HSV converter. It
// predicts hue, saturation and value for every accepted pixel word and
// compares each result word, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module srgb_to_hsv_checker #(
	parameter int CODE_BITS   = 8,
	parameter int LINEAR_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [CODE_BITS-1:0]           red_code,
	input  logic [CODE_BITS-1:0]           green_code,
	input  logic [CODE_BITS-1:0]           blue_code,
	input  logic                           done,
	input  logic [s2hsv_pkg::HUE_BITS-1:0] hue,
	input  logic [LINEAR_BITS-1:0]         saturation,
	input  logic [LINEAR_BITS-1:0]         value,
	output int                             errors,
	output int                             pending,
	output int                             checked
);

	import s2hsv_pkg::*;

	localparam longint unsigned CODE_MAX = (64'd1 << CODE_BITS) - 64'd1;
	localparam longint unsigned LIN_MAX  = (64'd1 << LINEAR_BITS) - 64'd1;
	localparam int              TABLE_N  = 1 << CODE_BITS;

	// One predicted result word, with the pixel that caused it.
	typedef struct packed {
		logic [CODE_BITS-1:0]   red;
		logic [CODE_BITS-1:0]   green;
		logic [CODE_BITS-1:0]   blue;
		logic [HUE_BITS-1:0]    hue;
		logic [LINEAR_BITS-1:0] sat;
		logic [LINEAR_BITS-1:0] val;
	} hsv_word_t;

	longint unsigned linear_level [TABLE_N];
	hsv_word_t       hsv_pending_q [$];

	// True when y is not above round half up of LIN_MAX * lin(c / CODE_MAX).
	// The power segment compares (2y - 1)^5 * d^12 with 32 * LIN_MAX^5 * n^12,
	// where n / d is the scaled base of the 2.4 power.
	function automatic bit level_not_above(longint unsigned c, longint unsigned y);
		longint unsigned n;
		longint unsigned d;
		logic [511:0]    lhs;
		logic [511:0]    rhs;
		logic [511:0]    term;
		if (c * 64'd100000 <= 64'd4045 * CODE_MAX) begin
			return y * 64'd2584 * CODE_MAX <= 64'd200 * c * LIN_MAX + 64'd1292 * CODE_MAX;
		end
		n = 64'd1000 * c + 64'd55 * CODE_MAX;
		d = 64'd1055 * CODE_MAX;
		term = 2 * y - 1;
		lhs = 1;
		for (int i = 0; i < 5; i++) begin
			lhs = lhs * term;
		end
		term = d;
		for (int i = 0; i < 12; i++) begin
			lhs = lhs * term;
		end
		rhs = 32;
		term = LIN_MAX;
		for (int i = 0; i < 5; i++) begin
			rhs = rhs * term;
		end
		term = n;
		for (int i = 0; i < 12; i++) begin
			rhs = rhs * term;
		end
		return lhs <= rhs;
	endfunction

	// Start from a floating-point estimate, then settle it by exact tests.
	function automatic longint unsigned linearize(longint unsigned c);
		real             x;
		real             lin;
		longint unsigned y;
		x = real'(c) / real'(CODE_MAX);
		if (x <= 0.04045) begin
			lin = x / 12.92;
		end else begin
			lin = ((x + 0.055) / 1.055) ** 2.4;
		end
		y = longint'($rtoi(real'(LIN_MAX) * lin + 0.5));
		if (y > LIN_MAX) begin
			y = LIN_MAX;
		end
		while (y > 0 && !level_not_above(c, y)) begin
			y--;
		end
		while (y < LIN_MAX && level_not_above(c, y + 1)) begin
			y++;
		end
		return y;
	endfunction

	// Hue, saturation and value of one pixel from its linear channels.
	function automatic hsv_word_t predict_hsv(logic [CODE_BITS-1:0] rc,
			logic [CODE_BITS-1:0] gc, logic [CODE_BITS-1:0] bc);
		longint        r;
		longint        g;
		longint        b;
		longint        mx;
		longint        mn;
		longint        diff;
		longint        num;
		longint        angle;
		s2hsv_sector_t sector;
		hsv_word_t     w;
		r = longint'(linear_level[rc]);
		g = longint'(linear_level[gc]);
		b = longint'(linear_level[bc]);
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		diff = mx - mn;
		w = '0;
		w.red = rc;
		w.green = gc;
		w.blue = bc;
		if (mx != 0) begin
			w.val = LINEAR_BITS'(mx);
			w.sat = LINEAR_BITS'((longint'(LIN_MAX) * diff) / mx);
			if (diff != 0) begin
				// Blue wins ties over green, green over red.
				if (b == mx) sector = SECTOR_BLUE;
				else if (g == mx) sector = SECTOR_GREEN;
				else sector = SECTOR_RED;
				case (sector)
					SECTOR_BLUE: begin
						angle = longint'(BASE_BLUE);
						num = r - g;
					end
					SECTOR_GREEN: begin
						angle = longint'(BASE_GREEN);
						num = b - r;
					end
					default: begin
						angle = longint'(BASE_RED);
						num = g - b;
					end
				endcase
				// Floor of the scaled ratio, rounding toward minus infinity.
				if (num >= 0) begin
					angle = angle + (num * SECTOR_SPAN) / diff;
				end else begin
					angle = angle - ((-num * SECTOR_SPAN + diff - 1) / diff);
				end
				if (angle < 0) begin
					angle = angle + FULL_TURN;
				end
				w.hue = HUE_BITS'(angle);
			end
		end
		return w;
	endfunction

	// The linearization table is constant, so it is built once up front.
	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		for (int c = 0; c < TABLE_N; c++) begin
			linear_level[c] = linearize(longint'(c));
		end
	end

	// Compare result words first, then record the pixel word of this edge.
	always @(posedge clk) begin
		hsv_word_t want;
		if (arst_n) begin
			if (done) begin
				if (hsv_pending_q.size() == 0) begin
					$display("%0t: result word with none expected: hue %0d sat %0d val %0d",
						$time, hue, saturation, value);
					errors++;
				end else begin
					want = hsv_pending_q.pop_front();
					checked++;
					if (hue !== want.hue || saturation !== want.sat || value !== want.val) begin
						$display("%0t: mismatch for rgb %0d %0d %0d", $time,
							want.red, want.green, want.blue);
						$display("    expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
							want.hue, want.sat, want.val, hue, saturation, value);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				hsv_pending_q.push_back(predict_hsv(red_code, green_code, blue_code));
			end
			pending = hsv_pending_q.size();
		end
	end

endmodule

FILE: test/tb_srgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// tb_srgb_to_hsv_converter_top
// Drives pixel words into the sRGB to HSV converter: a directed set of black,
// grey, tie, hue wrap and linear knee pixels, then random pixels with random
// gaps. A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_srgb_to_hsv_converter_top;

	localparam int CODE_BITS      = 8;
	localparam int LINEAR_BITS    = 16;
	localparam int RANDOM_PIXELS  = 700;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int CODE_TOP       = (1 << CODE_BITS) - 1;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [CODE_BITS-1:0]           red_code;
	logic [CODE_BITS-1:0]           green_code;
	logic [CODE_BITS-1:0]           blue_code;
	logic                           done;
	logic [s2hsv_pkg::HUE_BITS-1:0] hue;
	logic [LINEAR_BITS-1:0]         saturation;
	logic [LINEAR_BITS-1:0]         value;

	int errors;
	int pending;
	int checked;
	int pixels_sent;
	int directed_sent;
	int idle_cycles;
	bit gaps_on;

	srgb_to_hsv_converter_top #(
		.CODE_BITS  (CODE_BITS),
		.LINEAR_BITS(LINEAR_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_code  (red_code),
		.green_code(green_code),
		.blue_code (blue_code),
		.done      (done),
		.hue       (hue),
		.saturation(saturation),
		.value     (value)
	);

	srgb_to_hsv_checker #(
		.CODE_BITS  (CODE_BITS),
		.LINEAR_BITS(LINEAR_BITS)
	) hsv_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_code  (red_code),
		.green_code(green_code),
		.blue_code (blue_code),
		.done      (done),
		.hue       (hue),
		.saturation(saturation),
		.value     (value),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: too many cycles in a row with no word moving ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL srgb_to_hsv_converter_top");
				$finish;
			end
		end
	end

	// Offer one pixel word, after a random gap when gaps are enabled.
	// Called and left at a falling edge; start stays high for a back-to-back word.
	task automatic send_pixel(input int r, input int g, input int b);
		int gap;
		gap = gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		red_code <= CODE_BITS'(r);
		green_code <= CODE_BITS'(g);
		blue_code <= CODE_BITS'(b);
		do begin
			@(posedge clk);
		end while (busy);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Hold the sender off until every predicted result word has arrived.
	task automatic drain_results();
		start <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	function automatic int clamp_code(int c);
		if (c < 0) return 0;
		if (c > CODE_TOP) return CODE_TOP;
		return c;
	endfunction

	// Random pixel shaped toward the interesting regions of the conversion.
	task automatic random_pixel(output int r, output int g, output int b);
		int shape;
		int base;
		shape = $urandom_range(0, 9);
		r = $urandom_range(0, CODE_TOP);
		g = $urandom_range(0, CODE_TOP);
		b = $urandom_range(0, CODE_TOP);
		case (shape)
			4, 5: begin
				// Nearly grey: small differences stress the hue division.
				base = $urandom_range(0, CODE_TOP);
				r = clamp_code(base + $urandom_range(0, 6) - 3);
				g = clamp_code(base + $urandom_range(0, 6) - 3);
				b = clamp_code(base + $urandom_range(0, 6) - 3);
			end
			6: begin
				// Two channels tied.
				case ($urandom_range(0, 2))
					0: g = r;
					1: b = g;
					default: b = r;
				endcase
			end
			7: begin
				r = $urandom_range(0, 1) ? CODE_TOP : 0;
				g = $urandom_range(0, 1) ? CODE_TOP : 0;
				b = $urandom_range(0, 1) ? CODE_TOP : 0;
			end
			8: begin
				case ($urandom_range(0, 2))
					0: r = 0;
					1: g = 0;
					default: b = 0;
				endcase
			end
			9: begin
				// Around the knee between the linear and power segments.
				r = $urandom_range(0, 20);
				g = $urandom_range(0, 20);
				b = $urandom_range(0, 20);
			end
			default: ;
		endcase
	endtask

	// Stimulus and verdict.
	initial begin
		int r;
		int g;
		int b;
		arst_n = 1'b0;
		start = 1'b0;
		red_code = '0;
		green_code = '0;
		blue_code = '0;
		pixels_sent = 0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pixels: black, grey, primaries, ties, hue wrap, the knee.
		send_pixel(0, 0, 0);
		send_pixel(CODE_TOP, CODE_TOP, CODE_TOP);
		send_pixel(128, 128, 128);
		send_pixel(CODE_TOP, 0, 0);
		send_pixel(0, CODE_TOP, 0);
		send_pixel(0, 0, CODE_TOP);
		send_pixel(CODE_TOP, CODE_TOP, 0);
		send_pixel(0, CODE_TOP, CODE_TOP);
		send_pixel(CODE_TOP, 0, CODE_TOP);
		send_pixel(200, 200, 50);
		gaps_on = 1'b1;
		send_pixel(CODE_TOP, 0, 10);
		send_pixel(CODE_TOP, 10, 0);
		send_pixel(10, CODE_TOP, 40);
		send_pixel(40, CODE_TOP, 10);
		send_pixel(30, 60, CODE_TOP);
		send_pixel(60, 30, CODE_TOP);
		send_pixel(1, 0, 0);
		send_pixel(0, 0, 1);
		send_pixel(10, 11, 10);
		send_pixel(11, 10, 12);
		send_pixel(254, CODE_TOP, 253);
		send_pixel(170, 85, 170);
		directed_sent = pixels_sent;
		drain_results();

		// Random pixels in stretches with and without gaps.
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % 40 == 0) begin
				gaps_on = $urandom_range(0, 2) != 0;
			end
			if (i == RANDOM_PIXELS / 2) begin
				drain_results();
			end
			random_pixel(r, g, b);
			send_pixel(r, g, b);
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d pixels (%0d directed), %0d result words checked;", pixels_sent,
			directed_sent, checked);
		$display("covered black, grey, tied maxima, hue wrap and knee codes, with random gaps.");
		if (errors == 0 && pending == 0) begin
			$display("PASS srgb_to_hsv_converter_top");
		end else begin
			$display("FAIL srgb_to_hsv_converter_top");
		end
		$finish;
	end

endmodule
